// ----- design/seven_segment_two_wire_writer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the two-wire display writer
// Shared property wrappers, clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_TWO_WIRE_WRITER_UNIT_DEFINES_SVH
`define SEVEN_SEGMENT_TWO_WIRE_WRITER_UNIT_DEFINES_SVH

// checked outside reset
`define SSWR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset as well
`define SSWR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/sswr_pkg.sv -----
// ----------------------------------------------------------------------------
// sswr_pkg
// Types and constants of the two-wire display writer.
// ----------------------------------------------------------------------------
package sswr_pkg;

   localparam int SEG_W   = 8;
   localparam int CNT_W   = 3;
   localparam int POS_W   = 3;
   localparam int BRT_W   = 3;
   localparam int SEG_NUM = 4;
   localparam int DIGITS  = 4;

   localparam logic [CNT_W-1:0] SEG_LIMIT = CNT_W'((DIGITS < SEG_NUM) ? DIGITS : SEG_NUM);

   localparam logic [SEG_W-1:0] CMD_MODE = 8'h40;
   localparam logic [SEG_W-1:0] CMD_ADDR = 8'hC0;
   localparam logic [SEG_W-1:0] CMD_CTRL = 8'h88;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef enum logic [13:0] {
      PH_IDLE    = 14'h0001,
      PH_S_DLOW  = 14'h0002,
      PH_S_CLOW  = 14'h0004,
      PH_B_CLOW  = 14'h0008,
      PH_B_DATA  = 14'h0010,
      PH_B_CHIGH = 14'h0020,
      PH_A_CLOW  = 14'h0040,
      PH_A_REL   = 14'h0080,
      PH_A_CHIGH = 14'h0100,
      PH_A_DRIVE = 14'h0200,
      PH_A_CLOW2 = 14'h0400,
      PH_P_DLOW  = 14'h0800,
      PH_P_CHIGH = 14'h1000,
      PH_P_DHIGH = 14'h2000
   } phase_type;

   typedef struct packed {
      logic             op;
      logic [SEG_W-1:0] seg_first;
      logic [SEG_W-1:0] seg_second;
      logic [SEG_W-1:0] seg_third;
      logic [SEG_W-1:0] seg_fourth;
      logic [CNT_W-1:0] seg_count;
      logic [POS_W-1:0] start_pos;
      logic             dio_in;
   } req_beat_type;

   typedef struct packed {
      logic en;
      req_beat_type item;
   } step_type;

   typedef struct packed {
      logic clk_level;
      logic dio_level;
      logic dio_drive;
      logic busy_res;
      logic frame_done;
      logic nack_seen;
   } rsp_beat_type;

endpackage

// ----- design/sswr_channels.sv -----
// ----------------------------------------------------------------------------
// sswr channels
// Valid/ready channel interfaces for request and response beats.
// ----------------------------------------------------------------------------
interface sswr_req_if;
   import sswr_pkg::*;

   logic             valid;
   logic             ready;
   logic             op;
   logic [SEG_W-1:0] seg_first;
   logic [SEG_W-1:0] seg_second;
   logic [SEG_W-1:0] seg_third;
   logic [SEG_W-1:0] seg_fourth;
   logic [CNT_W-1:0] seg_count;
   logic [POS_W-1:0] start_pos;
   logic             dio_in;

   modport source (output valid, op, seg_first, seg_second, seg_third, seg_fourth,
                   seg_count, start_pos, dio_in, input ready);
   modport sink   (input valid, op, seg_first, seg_second, seg_third, seg_fourth,
                   seg_count, start_pos, dio_in, output ready);
endinterface

interface sswr_rsp_if;
   logic valid;
   logic ready;
   logic clk_level;
   logic dio_level;
   logic dio_drive;
   logic busy_res;
   logic frame_done;
   logic nack_seen;

   modport source (output valid, clk_level, dio_level, dio_drive, busy_res,
                   frame_done, nack_seen, input ready);
   modport sink   (input valid, clk_level, dio_level, dio_drive, busy_res,
                   frame_done, nack_seen, output ready);
endinterface

// ----- design/seven_segment_two_wire_writer_unit.sv -----
// ----------------------------------------------------------------------------
// seven_segment_two_wire_writer_unit
// Two-wire LED display writer: request beats load a frame, tick beats
// step the clock and data pins one phase each.
// ----------------------------------------------------------------------------
//  port      dir  kind         content
//  req_chan  in   valid/ready  op, four segment bytes, count, position, dio_in
//  rsp_chan  out  valid/ready  pin levels, drive, busy, done, nack
//  csr_*     in   write only   brightness
//
//  One beat per cycle while the response channel is ready; a request beat passes
//  the input register, then the response register, before its response appears.
//  Reset is synchronous, active high; pins idle high, no frame in flight.
//  A stalled response holds the pipe, at most two beats inside; the input
//  register takes a beat when it is empty or its beat moves on.
// ----------------------------------------------------------------------------
module seven_segment_two_wire_writer_unit (
   input  logic                         clock,
   input  logic                         reset,
   sswr_req_if.sink                     req_chan,
   sswr_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [sswr_pkg::BRT_W-1:0]   csr_wr_data
);
   import sswr_pkg::*;

   logic               req_valid_ff, req_valid_in;
   req_beat_type       req_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_beat_type       rsp_ff;
   logic [BRT_W-1:0]   brightness_ff;
   logic               out_adv;
   step_type           step;
   rsp_beat_type       result;

   assign out_adv        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !req_valid_ff || out_adv;
   assign req_valid_in   = req_chan.ready ? req_chan.valid : req_valid_ff;
   assign rsp_valid_in   = out_adv ? req_valid_ff : rsp_valid_ff;

   assign step.en   = req_valid_ff && out_adv;
   assign step.item = req_ff;

   sswr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .brightness (brightness_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         brightness_ff <= 3'd7;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            brightness_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_ff.op         <= req_chan.op;
         req_ff.seg_first  <= req_chan.seg_first;
         req_ff.seg_second <= req_chan.seg_second;
         req_ff.seg_third  <= req_chan.seg_third;
         req_ff.seg_fourth <= req_chan.seg_fourth;
         req_ff.seg_count  <= req_chan.seg_count;
         req_ff.start_pos  <= req_chan.start_pos;
         req_ff.dio_in     <= req_chan.dio_in;
      end
      if (step.en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.clk_level  = rsp_ff.clk_level;
   assign rsp_chan.dio_level  = rsp_ff.dio_level;
   assign rsp_chan.dio_drive  = rsp_ff.dio_drive;
   assign rsp_chan.busy_res   = rsp_ff.busy_res;
   assign rsp_chan.frame_done = rsp_ff.frame_done;
   assign rsp_chan.nack_seen  = rsp_ff.nack_seen;

endmodule

// ----- design/sswr_seq.sv -----
// ----------------------------------------------------------------------------
// sswr_seq
// Pin phase sequencer: a load in idle starts a frame, ticks step it one phase.
// ----------------------------------------------------------------------------
module sswr_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  sswr_pkg::step_type            step,
   input  logic [sswr_pkg::BRT_W-1:0]    brightness,
   output sswr_pkg::rsp_beat_type        result
);
   import sswr_pkg::*;

   phase_type        phase_ff,   phase_in;
   logic [2:0]       cmd_idx_ff, cmd_idx_in;
   logic [2:0]       bit_idx_ff, bit_idx_in;
   logic [SEG_W-1:0] shift_ff,   shift_in;
   logic [SEG_W-1:0] seg_buf_ff [SEG_NUM];
   logic [CNT_W-1:0] held_cnt_ff, held_cnt_in;
   logic [POS_W-1:0] held_pos_ff, held_pos_in;
   logic             clk_lvl_ff, clk_lvl_in;
   logic             dio_lvl_ff, dio_lvl_in;
   logic             nack_ff,    nack_in;

   logic             load_seg;
   logic [2:0]       last_idx;
   logic [2:0]       load_idx;
   logic [1:0]       buf_sel;
   logic [SEG_W-1:0] load_byte;
   logic             done;

   assign last_idx = 3'(held_cnt_ff + 3'd2);
   assign load_idx = (phase_ff == PH_A_CLOW2) ? 3'(cmd_idx_ff + 3'd1) : cmd_idx_ff;
   assign buf_sel  = 2'(load_idx - 3'd2);

   always_comb begin
      if (load_idx == 3'd0) begin
         load_byte = CMD_MODE;
      end else if (load_idx == 3'd1) begin
         load_byte = CMD_ADDR | {{(SEG_W-POS_W){1'b0}}, held_pos_ff};
      end else if (load_idx < last_idx) begin
         load_byte = seg_buf_ff[buf_sel];
      end else begin
         load_byte = CMD_CTRL | {{(SEG_W-BRT_W){1'b0}}, brightness};
      end
   end

   assign load_seg = step.en && (step.item.op == OP_LOAD) && (phase_ff == PH_IDLE);

   always_comb begin
      phase_in    = phase_ff;
      cmd_idx_in  = cmd_idx_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      held_cnt_in = held_cnt_ff;
      held_pos_in = held_pos_ff;
      clk_lvl_in  = clk_lvl_ff;
      dio_lvl_in  = dio_lvl_ff;
      nack_in     = nack_ff;
      done        = 1'b0;
      if (load_seg) begin
         held_cnt_in = (step.item.seg_count > SEG_LIMIT) ? SEG_LIMIT : step.item.seg_count;
         held_pos_in = step.item.start_pos;
         cmd_idx_in  = 3'd0;
         bit_idx_in  = 3'd0;
         nack_in     = 1'b0;
         phase_in    = PH_S_DLOW;
      end else if (step.en && step.item.op == OP_TICK) begin
         case (phase_ff)
            PH_IDLE: begin
            end
            PH_S_DLOW: begin
               dio_lvl_in = 1'b0;
               phase_in   = PH_S_CLOW;
            end
            PH_S_CLOW: begin
               clk_lvl_in = 1'b0;
               shift_in   = load_byte;
               bit_idx_in = 3'd0;
               phase_in   = PH_B_CLOW;
            end
            PH_B_CLOW: begin
               clk_lvl_in = 1'b0;
               phase_in   = PH_B_DATA;
            end
            PH_B_DATA: begin
               dio_lvl_in = shift_ff[0];
               phase_in   = PH_B_CHIGH;
            end
            PH_B_CHIGH: begin
               clk_lvl_in = 1'b1;
               shift_in   = shift_ff >> 1;
               if (bit_idx_ff == 3'd7) begin
                  phase_in = PH_A_CLOW;
               end else begin
                  bit_idx_in = 3'(bit_idx_ff + 3'd1);
                  phase_in   = PH_B_CLOW;
               end
            end
            PH_A_CLOW: begin
               clk_lvl_in = 1'b0;
               phase_in   = PH_A_REL;
            end
            PH_A_REL: begin
               phase_in = PH_A_CHIGH;
            end
            PH_A_CHIGH: begin
               clk_lvl_in = 1'b1;
               if (step.item.dio_in) begin
                  nack_in = 1'b1;
               end
               phase_in = PH_A_DRIVE;
            end
            PH_A_DRIVE: begin
               phase_in = PH_A_CLOW2;
            end
            PH_A_CLOW2: begin
               clk_lvl_in = 1'b0;
               if (cmd_idx_ff == 3'd0 || cmd_idx_ff >= 3'(last_idx - 3'd1)) begin
                  phase_in = PH_P_DLOW;
               end else begin
                  cmd_idx_in = load_idx;
                  shift_in   = load_byte;
                  bit_idx_in = 3'd0;
                  phase_in   = PH_B_CLOW;
               end
            end
            PH_P_DLOW: begin
               dio_lvl_in = 1'b0;
               phase_in   = PH_P_CHIGH;
            end
            PH_P_CHIGH: begin
               clk_lvl_in = 1'b1;
               phase_in   = PH_P_DHIGH;
            end
            PH_P_DHIGH: begin
               dio_lvl_in = 1'b1;
               if (cmd_idx_ff >= last_idx) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  cmd_idx_in = (cmd_idx_ff == 3'd0) ? 3'd1 : last_idx;
                  phase_in   = PH_S_DLOW;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         cmd_idx_ff  <= 3'd0;
         bit_idx_ff  <= 3'd0;
         held_cnt_ff <= '0;
         held_pos_ff <= '0;
         clk_lvl_ff  <= 1'b1;
         dio_lvl_ff  <= 1'b1;
         nack_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         cmd_idx_ff  <= cmd_idx_in;
         bit_idx_ff  <= bit_idx_in;
         held_cnt_ff <= held_cnt_in;
         held_pos_ff <= held_pos_in;
         clk_lvl_ff  <= clk_lvl_in;
         dio_lvl_ff  <= dio_lvl_in;
         nack_ff     <= nack_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (load_seg) begin
         seg_buf_ff[0] <= step.item.seg_first;
         seg_buf_ff[1] <= step.item.seg_second;
         seg_buf_ff[2] <= step.item.seg_third;
         seg_buf_ff[3] <= step.item.seg_fourth;
      end
   end

   assign result.clk_level  = clk_lvl_in;
   assign result.dio_level  = dio_lvl_in;
   assign result.dio_drive  = !(phase_in == PH_A_CHIGH || phase_in == PH_A_DRIVE);
   assign result.busy_res   = (phase_in != PH_IDLE);
   assign result.frame_done = done;
   assign result.nack_seen  = nack_in;

endmodule

// ----- design/sswr_checker.sv -----
// ----------------------------------------------------------------------------
// sswr_checker
// Port-level checks on the response channel of the display writer.
// ----------------------------------------------------------------------------
`include "seven_segment_two_wire_writer_unit_defines.svh"

module sswr_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic clk_level,
   input logic dio_level,
   input logic dio_drive,
   input logic busy_res,
   input logic frame_done
);

   `SSWR_ASSERT_ALWAYS(a_rst_empty, reset |=> !rsp_valid, "response valid after reset")
   `SSWR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response beat dropped")
   `SSWR_ASSERT(a_done_idle, rsp_valid && frame_done |-> !busy_res, "done while busy")
   `SSWR_ASSERT(a_done_pins, rsp_valid && frame_done |-> clk_level && dio_level, "stop not high")
   `SSWR_ASSERT(a_ack_slot, rsp_valid && !dio_drive |-> busy_res, "bad ack slot")

endmodule

bind seven_segment_two_wire_writer_unit sswr_checker u_sswr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .clk_level  (rsp_chan.clk_level),
   .dio_level  (rsp_chan.dio_level),
   .dio_drive  (rsp_chan.dio_drive),
   .busy_res   (rsp_chan.busy_res),
   .frame_done (rsp_chan.frame_done)
);
